// File: src/pgs_rle_pkg.sv
// Types, codes and sizes shared by the subtitle run-length decoder.
// No dependencies.
package pgs_rle_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int LEN_W      = 14;
  localparam int RUN_W      = 13;
  localparam int COL_W      = 12;
  localparam int ROW_OUT_W  = 13;
  localparam int RES_DEPTH  = 4;
  localparam int RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  typedef enum logic [3:0] {
    PH_COLOR    = 4'b0001,
    PH_FLAGS    = 4'b0010,
    PH_LOWLEN   = 4'b0100,
    PH_ESCCOLOR = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RUN      = 2'd0,
    KIND_EOL      = 2'd1,
    KIND_COMPLETE = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TRUNCATED = 3'd1,
    ERR_LINE_LEN  = 3'd2,
    ERR_CROSSES   = 3'd3,
    ERR_FEW_ROWS  = 3'd4,
    ERR_TRAILING  = 3'd5
  } err_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           color;
    logic [RUN_W-1:0]     run_length;
    logic [COL_W-1:0]     column;
    logic [ROW_OUT_W-1:0] row;
    err_t                 error_code;
    logic                 last_result;
  } res_t;

  function automatic res_t make_rec(kind_t k, logic [7:0] c, logic [RUN_W-1:0] len,
                                    logic [COL_W-1:0] col, logic [ROW_OUT_W-1:0] r,
                                    err_t e);
    res_t x;
    x.kind        = k;
    x.color       = c;
    x.run_length  = len;
    x.column      = col;
    x.row         = r;
    x.error_code  = e;
    x.last_result = 1'b0;
    return x;
  endfunction

endpackage

// File: src/pgs_rle_run_decoder.sv
// Subtitle bitmap run-length decoder: escape parser, position tracking, result queue.
// Depends on pgs_rle_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one coded byte per beat with
//   first_byte (starts a new image) and last_byte (final byte of the image).
//   Output channel (out_valid / out_stall) carries result records: pixel run,
//   end of line, image complete or numbered error; last_result marks the final
//   record caused by one input byte. Each byte gives zero, one or two records.
//   Configuration: write image_width (index 0) and image_height (index 1)
//   through cfg_write / cfg_index / cfg_data while the block is idle.
// Path: a byte lands in the input register at its accepting edge, is decoded
//   from there and its records are written to the result queue, whose head drives
//   the output.
// Throughput: one byte per cycle while bytes give at most one record and the
//   receiver does not stall; two-record bytes fill the queue via the single-record
//   output port. A four-entry result queue takes a byte only with room for two.
// Stall: a stalled receiver fills the queue, then the input register holds and
//   in_stall rises; nothing is dropped.
// Reset: rst (synchronous) clears the queue, the parser to the color-byte
//   phase, position to zero and both dimension registers to 1.
module pgs_rle_run_decoder #(
  parameter int MAX_WIDTH  = pgs_rle_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pgs_rle_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [pgs_rle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pgs_rle_pkg::CFG_W-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           data_byte,
  input  logic                                 first_byte,
  input  logic                                 last_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           kind,
  output logic [7:0]                           color,
  output logic [pgs_rle_pkg::RUN_W-1:0]        run_length,
  output logic [pgs_rle_pkg::COL_W-1:0]        column,
  output logic [pgs_rle_pkg::ROW_OUT_W-1:0]    row,
  output logic [2:0]                           error_code,
  output logic                                 last_result
);

  localparam int POS_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
  localparam int LEN_W = pgs_rle_pkg::LEN_W;

  logic [pgs_rle_pkg::CFG_W-1:0] image_width;
  logic [pgs_rle_pkg::CFG_W-1:0] image_height;

  logic       ireg_valid;
  logic [7:0] ireg_byte;
  logic       ireg_first;
  logic       ireg_last;

  pgs_rle_pkg::phase_t phase, phase_next;
  logic [POS_W-1:0]    column_pos, column_pos_next;
  logic [ROW_W-1:0]    row_pos, row_pos_next;
  logic [LEN_W-1:0]    pending_length, pending_length_next;
  logic [1:0]          pending_flags, pending_flags_next;
  logic                halted, halted_next;

  logic [POS_W-1:0] w;
  logic [ROW_W-1:0] h;

  logic             run_req;
  logic [7:0]       run_color;
  logic [LEN_W-1:0] run_len;
  logic [LEN_W-1:0] room;
  logic             rec_a_v, rec_b_v;
  pgs_rle_pkg::res_t rec_a, rec_b, slot0, slot1;
  logic [1:0]       push_n;

  pgs_rle_pkg::res_t entries [pgs_rle_pkg::RES_DEPTH];
  logic [pgs_rle_pkg::RES_PTR_W-1:0] head, tail;
  logic [pgs_rle_pkg::RES_CNT_W-1:0] count;
  logic fire, pop;

  assign fire     = ireg_valid && (count <= pgs_rle_pkg::RES_CNT_W'(pgs_rle_pkg::RES_DEPTH - 2));
  assign in_stall = ireg_valid && !fire;
  assign pop      = out_valid && !out_stall;

  always_comb begin
    if (image_width == '0) begin
      w = POS_W'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w = POS_W'(MAX_WIDTH);
    end else begin
      w = POS_W'(image_width);
    end
    if (image_height == '0) begin
      h = ROW_W'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h = ROW_W'(MAX_HEIGHT);
    end else begin
      h = ROW_W'(image_height);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= pgs_rle_pkg::CFG_W'(1);
      image_height <= pgs_rle_pkg::CFG_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        pgs_rle_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        pgs_rle_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (!in_stall) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ireg_byte  <= data_byte;
      ireg_first <= first_byte;
      ireg_last  <= last_byte;
    end
  end

  // decode one byte
  always_comb begin
    phase_next          = phase;
    column_pos_next     = column_pos;
    row_pos_next        = row_pos;
    pending_length_next = pending_length;
    pending_flags_next  = pending_flags;
    halted_next         = halted;
    run_req   = 1'b0;
    run_color = 8'd0;
    run_len   = '0;
    room      = '0;
    rec_a_v   = 1'b0;
    rec_b_v   = 1'b0;
    rec_a     = '0;
    rec_b     = '0;

    if (ireg_first) begin
      phase_next          = pgs_rle_pkg::PH_COLOR;
      column_pos_next     = '0;
      row_pos_next        = '0;
      pending_length_next = '0;
      pending_flags_next  = '0;
      halted_next         = 1'b0;
    end

    if (!halted_next) begin
      case (phase_next)
        pgs_rle_pkg::PH_COLOR: begin
          if (row_pos_next >= h) begin
            rec_a_v     = 1'b1;
            rec_a       = pgs_rle_pkg::make_rec(pgs_rle_pkg::KIND_ERROR, 8'd0, '0,
                            pgs_rle_pkg::COL_W'(column_pos_next),
                            pgs_rle_pkg::ROW_OUT_W'(row_pos_next), pgs_rle_pkg::ERR_TRAILING);
            halted_next = 1'b1;
          end else if (ireg_byte != 8'd0) begin
            run_req   = 1'b1;
            run_color = ireg_byte;
            run_len   = LEN_W'(1);
          end else begin
            phase_next = pgs_rle_pkg::PH_FLAGS;
          end
        end
        pgs_rle_pkg::PH_FLAGS: begin
          pending_length_next = LEN_W'(ireg_byte[5:0]);
          pending_flags_next  = {ireg_byte[7], ireg_byte[6]};
          if (ireg_byte[6]) begin
            phase_next = pgs_rle_pkg::PH_LOWLEN;
          end else if (ireg_byte[7]) begin
            phase_next = pgs_rle_pkg::PH_ESCCOLOR;
          end else begin
            phase_next = pgs_rle_pkg::PH_COLOR;
            run_req    = 1'b1;
            run_len    = LEN_W'(ireg_byte[5:0]);
          end
        end
        pgs_rle_pkg::PH_LOWLEN: begin
          pending_length_next = {pending_length_next[5:0], ireg_byte};
          if (pending_flags_next[1]) begin
            phase_next = pgs_rle_pkg::PH_ESCCOLOR;
          end else begin
            phase_next = pgs_rle_pkg::PH_COLOR;
            run_req    = 1'b1;
            run_len    = pending_length_next;
          end
        end
        pgs_rle_pkg::PH_ESCCOLOR: begin
          phase_next = pgs_rle_pkg::PH_COLOR;
          run_req    = 1'b1;
          run_color  = ireg_byte;
          run_len    = pending_length_next;
        end
        default: begin
          phase_next = pgs_rle_pkg::PH_COLOR;
        end
      endcase

      if (run_req) begin
        rec_a_v = 1'b1;
        room    = LEN_W'(w) - LEN_W'(column_pos_next);
        if (run_len == '0) begin
          if (column_pos_next != w) begin
            rec_a       = pgs_rle_pkg::make_rec(pgs_rle_pkg::KIND_ERROR, 8'd0, '0,
                            pgs_rle_pkg::COL_W'(column_pos_next),
                            pgs_rle_pkg::ROW_OUT_W'(row_pos_next), pgs_rle_pkg::ERR_LINE_LEN);
            halted_next = 1'b1;
          end else begin
            rec_a           = pgs_rle_pkg::make_rec(pgs_rle_pkg::KIND_EOL, 8'd0, '0,
                                pgs_rle_pkg::COL_W'(column_pos_next),
                                pgs_rle_pkg::ROW_OUT_W'(row_pos_next), pgs_rle_pkg::ERR_NONE);
            column_pos_next = '0;
            row_pos_next    = row_pos_next + ROW_W'(1);
          end
        end else if (column_pos_next <= w && run_len > room) begin
          rec_a       = pgs_rle_pkg::make_rec(pgs_rle_pkg::KIND_ERROR, 8'd0, '0,
                          pgs_rle_pkg::COL_W'(column_pos_next),
                          pgs_rle_pkg::ROW_OUT_W'(row_pos_next), pgs_rle_pkg::ERR_CROSSES);
          halted_next = 1'b1;
        end else begin
          rec_a           = pgs_rle_pkg::make_rec(pgs_rle_pkg::KIND_RUN, run_color,
                              pgs_rle_pkg::RUN_W'(run_len),
                              pgs_rle_pkg::COL_W'(column_pos_next),
                              pgs_rle_pkg::ROW_OUT_W'(row_pos_next), pgs_rle_pkg::ERR_NONE);
          column_pos_next = POS_W'(LEN_W'(column_pos_next) + run_len);
        end
      end

      if (!halted_next && ireg_last) begin
        rec_b_v     = 1'b1;
        halted_next = 1'b1;
        if (phase_next != pgs_rle_pkg::PH_COLOR) begin
          rec_b = pgs_rle_pkg::make_rec(pgs_rle_pkg::KIND_ERROR, 8'd0, '0,
                    pgs_rle_pkg::COL_W'(column_pos_next),
                    pgs_rle_pkg::ROW_OUT_W'(row_pos_next), pgs_rle_pkg::ERR_TRUNCATED);
        end else if (row_pos_next == h ||
                     (row_pos_next == h - ROW_W'(1) && column_pos_next == w)) begin
          rec_b = pgs_rle_pkg::make_rec(pgs_rle_pkg::KIND_COMPLETE, 8'd0, '0, '0,
                    pgs_rle_pkg::ROW_OUT_W'(h), pgs_rle_pkg::ERR_NONE);
        end else begin
          rec_b = pgs_rle_pkg::make_rec(pgs_rle_pkg::KIND_ERROR, 8'd0, '0,
                    pgs_rle_pkg::COL_W'(column_pos_next),
                    pgs_rle_pkg::ROW_OUT_W'(row_pos_next), pgs_rle_pkg::ERR_FEW_ROWS);
        end
      end
    end
  end

  // pack the byte's records in order, mark the final one
  always_comb begin
    slot0  = rec_a;
    slot1  = rec_b;
    push_n = 2'd0;
    if (fire) begin
      if (rec_a_v && rec_b_v) begin
        push_n = 2'd2;
        slot1.last_result = 1'b1;
      end else if (rec_a_v) begin
        push_n = 2'd1;
        slot0.last_result = 1'b1;
      end else if (rec_b_v) begin
        push_n = 2'd1;
        slot0 = rec_b;
        slot0.last_result = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= pgs_rle_pkg::PH_COLOR;
      column_pos     <= '0;
      row_pos        <= '0;
      pending_length <= '0;
      pending_flags  <= '0;
      halted         <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      column_pos     <= column_pos_next;
      row_pos        <= row_pos_next;
      pending_length <= pending_length_next;
      pending_flags  <= pending_flags_next;
      halted         <= halted_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[tail] <= slot0;
    end
    if (push_n == 2'd2) begin
      entries[tail + pgs_rle_pkg::RES_PTR_W'(1)] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + pgs_rle_pkg::RES_PTR_W'(push_n);
      head  <= head + pgs_rle_pkg::RES_PTR_W'(pop);
      count <= count + pgs_rle_pkg::RES_CNT_W'(push_n) - pgs_rle_pkg::RES_CNT_W'(pop);
    end
  end

  assign out_valid   = (count != '0);
  assign kind        = entries[head].kind;
  assign color       = entries[head].color;
  assign run_length  = entries[head].run_length;
  assign column      = entries[head].column;
  assign row         = entries[head].row;
  assign error_code  = entries[head].error_code;
  assign last_result = entries[head].last_result;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pgs_rle_pkg::RES_CNT_W'(pgs_rle_pkg::RES_DEPTH))
    else $error("result queue overflow");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ireg_valid)
    else $error("input stalled with empty input register");

  a_grow_only_on_fire: assert property (@(posedge clk) disable iff (rst)
    !fire |=> count <= $past(count))
    else $error("queue grew without a decoded byte");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == pgs_rle_pkg::KIND_RUN |-> run_length != '0)
    else $error("empty run record");
`endif

endmodule

// File: dv/pgs_rle_run_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pgs_rle_run_decoder: directed byte table, then random images.
// Needs pgs_rle_pkg and the decoder RTL; records are checked against an in-bench decoder.
module pgs_rle_run_decoder_tb;
  import pgs_rle_pkg::*;

  localparam int LIMIT     = 400000;
  localparam int PER_PHASE = 192;
  localparam int MAX_W     = MAX_WIDTH_DEF;
  localparam int MAX_H     = MAX_HEIGHT_DEF;

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
  } coded_t;

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
    bit         typed;
    res_t       want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           data_byte = '0;
  logic                 first_byte = 1'b0;
  logic                 last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           kind;
  logic [7:0]           color;
  logic [RUN_W-1:0]     run_length;
  logic [COL_W-1:0]     column;
  logic [ROW_OUT_W-1:0] row;
  logic [2:0]           error_code;
  logic                 last_result;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  // decoder state mirrored in the bench
  logic [12:0] img_w_reg;
  logic [12:0] img_h_reg;
  phase_t      dec_phase;
  logic [12:0] col_pos;
  logic [12:0] row_pos;
  logic [13:0] pend_len;
  logic        pend_low;
  logic        pend_clr;
  bit          stopped;

  res_t   byte_recs[$];
  res_t   exp_q[$];
  coded_t img_q[$];

  pgs_rle_run_decoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .color       (color),
    .run_length  (run_length),
    .column      (column),
    .row         (row),
    .error_code  (error_code),
    .last_result (last_result)
  );

  always #10 clk = ~clk;

  function automatic res_t rec(kind_t k, logic [7:0] c, int len, int col, int r, err_t e);
    res_t x;
    x.kind        = k;
    x.color       = c;
    x.run_length  = len[RUN_W-1:0];
    x.column      = col[COL_W-1:0];
    x.row         = r[ROW_OUT_W-1:0];
    x.error_code  = e;
    x.last_result = 1'b1;
    return x;
  endfunction

  function automatic int dim_used(logic [12:0] v, int mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  task automatic halt_with(err_t code);
    byte_recs.push_back(rec(KIND_ERROR, 8'd0, 0, col_pos, row_pos, code));
    stopped = 1'b1;
  endtask

  task automatic place_run(logic [7:0] clr, int len, int w);
    if (len == 0) begin
      if (col_pos != w) begin
        halt_with(ERR_LINE_LEN);
      end else begin
        byte_recs.push_back(rec(KIND_EOL, 8'd0, 0, col_pos, row_pos, ERR_NONE));
        col_pos = '0;
        row_pos = row_pos + 1'b1;
      end
    end else if (len > w - col_pos) begin
      halt_with(ERR_CROSSES);
    end else begin
      byte_recs.push_back(rec(KIND_RUN, clr, len, col_pos, row_pos, ERR_NONE));
      col_pos = col_pos + len[12:0];
    end
  endtask

  task automatic decode_byte(logic [7:0] b, logic f, logic l, output bit ignored);
    int w;
    int h;
    w = dim_used(img_w_reg, MAX_W);
    h = dim_used(img_h_reg, MAX_H);
    byte_recs.delete();
    if (f) begin
      dec_phase = PH_COLOR;
      col_pos   = '0;
      row_pos   = '0;
      pend_len  = '0;
      pend_low  = 1'b0;
      pend_clr  = 1'b0;
      stopped   = 1'b0;
    end
    ignored = stopped;
    if (stopped) return;
    if (dec_phase == PH_COLOR && row_pos >= h) begin
      halt_with(ERR_TRAILING);
    end else begin
      case (dec_phase)
        PH_COLOR: begin
          if (b != 0) place_run(b, 1, w);
          else dec_phase = PH_FLAGS;
        end
        PH_FLAGS: begin
          pend_len = {8'd0, b[5:0]};
          pend_low = b[6];
          pend_clr = b[7];
          if (pend_low) begin
            dec_phase = PH_LOWLEN;
          end else if (pend_clr) begin
            dec_phase = PH_ESCCOLOR;
          end else begin
            dec_phase = PH_COLOR;
            place_run(8'd0, pend_len, w);
          end
        end
        PH_LOWLEN: begin
          pend_len = {pend_len[5:0], b};
          if (pend_clr) begin
            dec_phase = PH_ESCCOLOR;
          end else begin
            dec_phase = PH_COLOR;
            place_run(8'd0, pend_len, w);
          end
        end
        default: begin
          dec_phase = PH_COLOR;
          place_run(b, pend_len, w);
        end
      endcase
    end
    if (!stopped && l) begin
      if (dec_phase != PH_COLOR) begin
        halt_with(ERR_TRUNCATED);
      end else if (row_pos == h || (row_pos == h - 1 && col_pos == w)) begin
        byte_recs.push_back(rec(KIND_COMPLETE, 8'd0, 0, 0, h, ERR_NONE));
        stopped = 1'b1;
      end else begin
        halt_with(ERR_FEW_ROWS);
      end
    end
    for (int i = 0; i < byte_recs.size() - 1; i++) byte_recs[i].last_result = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val[CFG_W-1:0];
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_IMAGE_WIDTH) img_w_reg = val[12:0];
    else img_h_reg = val[12:0];
  endtask

  // hold the beat until accepted; record expectations at the accepting edge
  task automatic send_byte(logic [7:0] b, logic f, logic l, bit typed, res_t want,
                           output bit ignored);
    bit go;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    data_byte  = b;
    first_byte = f;
    last_byte  = l;
    forever begin
      go = !in_stall;
      @(posedge clk);
      if (go) break;
      @(negedge clk);
    end
    decode_byte(b, f, l, ignored);
    if (typed) begin
      exp_q.push_back(want);
    end else begin
      foreach (byte_recs[i]) exp_q.push_back(byte_recs[i]);
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_run(logic [7:0] clr, int len);
    int form;
    bit with_clr;
    form = $urandom_range(0, 2);
    with_clr = (clr != 0) || ($urandom_range(0, 1) == 1);
    if (len == 1 && clr != 0 && form == 0) begin
      img_q.push_back(coded_t'{clr, 1'b0, 1'b0});
    end else if (len < 64 && form != 2) begin
      img_q.push_back(coded_t'{8'h00, 1'b0, 1'b0});
      img_q.push_back(coded_t'{{with_clr, 1'b0, 6'(len)}, 1'b0, 1'b0});
      if (with_clr) img_q.push_back(coded_t'{clr, 1'b0, 1'b0});
    end else begin
      img_q.push_back(coded_t'{8'h00, 1'b0, 1'b0});
      img_q.push_back(coded_t'{{with_clr, 1'b1, 6'(len >> 8)}, 1'b0, 1'b0});
      img_q.push_back(coded_t'{8'(len), 1'b0, 1'b0});
      if (with_clr) img_q.push_back(coded_t'{clr, 1'b0, 1'b0});
    end
  endtask

  // mostly well-formed images; some get a corrupted byte, a cut, extra bytes or pure noise
  task automatic build_image();
    int w;
    int h;
    int rows;
    int rem;
    int len;
    int mode;
    int cut;
    logic [7:0] clr;
    w = dim_used(img_w_reg, MAX_W);
    h = dim_used(img_h_reg, MAX_H);
    img_q.delete();
    mode = $urandom_range(0, 99);
    if (mode >= 94) begin
      repeat ($urandom_range(1, 8))
        img_q.push_back(coded_t'{8'($urandom), 1'($urandom), 1'($urandom)});
      return;
    end
    rows = (h <= 8) ? h : $urandom_range(1, 3);
    for (int r = 0; r < rows; r++) begin
      rem = w;
      while (rem > 0) begin
        if ($urandom_range(0, 1) == 1) len = $urandom_range(1, (rem < 8) ? rem : 8);
        else len = $urandom_range(1, rem);
        clr = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
        put_run(clr, len);
        rem -= len;
      end
      if (r < rows - 1 || $urandom_range(0, 1) == 1) put_run(8'($urandom), 0);
    end
    img_q[0].first = 1'b1;
    img_q[img_q.size() - 1].last = 1'b1;
    if (mode >= 70 && mode < 80) begin
      img_q[$urandom_range(0, img_q.size() - 1)].data = 8'($urandom);
    end else if (mode >= 80 && mode < 88) begin
      cut = $urandom_range(1, img_q.size());
      while (img_q.size() > cut) void'(img_q.pop_back());
      img_q[img_q.size() - 1].last = 1'b1;
    end else if (mode >= 88) begin
      img_q[img_q.size() - 1].last = 1'b0;
      repeat ($urandom_range(1, 3)) img_q.push_back(coded_t'{8'($urandom), 1'b0, 1'b0});
      img_q[img_q.size() - 1].last = 1'b1;
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      got.kind        = kind_t'(kind);
      got.color       = color;
      got.run_length  = run_length;
      got.column      = column;
      got.row         = row;
      got.error_code  = err_t'(error_code);
      got.last_result = last_result;
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected record kind %0d color %0d len %0d col %0d row %0d err %0d",
                   $realtime, kind, color, run_length, column, row, error_code);
      end else begin
        want = exp_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"%0t: exp kind %0d color %0d len %0d col %0d row %0d err %0d last %0d",
                      " / got kind %0d color %0d len %0d col %0d row %0d err %0d last %0d"},
                     $realtime, want.kind, want.color, want.run_length, want.column,
                     want.row, want.error_code, want.last_result, got.kind, got.color,
                     got.run_length, got.column, got.row, got.error_code, got.last_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("pgs_rle_run_decoder_tb: errors");
      $finish;
    end
  end

  initial begin
    stim_row_t tab[$];
    res_t      nil;
    bit        ign;
    bit        paused;
    int        counted;
    int        ph_w[6] = '{0, 5, 8191, 4096, 13, 2};
    int        ph_h[6] = '{0, 3, 2, 8191, 4, 1};
    int        ph_idle[6] = '{0, 63, 0, 28, 0, 63};
    int        ph_stall[6] = '{0, 0, 63, 28, 0, 0};

    nil       = '0;
    paused    = 1'b0;
    img_w_reg = 13'd1;
    img_h_reg = 13'd1;
    dec_phase = PH_COLOR;
    col_pos   = '0;
    row_pos   = '0;
    pend_len  = '0;
    pend_low  = 1'b0;
    pend_clr  = 1'b0;
    stopped   = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // 4 x 1 image: plain pixels, escapes, trailing byte, halt, every error code
    write_reg(REG_IMAGE_WIDTH, 4);
    write_reg(REG_IMAGE_HEIGHT, 1);
    tab.push_back(stim_row_t'{8'h05, 1, 0, 1, rec(KIND_RUN, 8'h05, 1, 0, 0, ERR_NONE)});
    tab.push_back(stim_row_t'{8'h00, 0, 0, 0, nil});
    tab.push_back(stim_row_t'{8'h83, 0, 0, 0, nil});
    tab.push_back(stim_row_t'{8'hff, 0, 0, 1, rec(KIND_RUN, 8'hff, 3, 1, 0, ERR_NONE)});
    tab.push_back(stim_row_t'{8'h00, 0, 0, 0, nil});
    tab.push_back(stim_row_t'{8'h00, 0, 0, 1, rec(KIND_EOL, 8'h00, 0, 4, 0, ERR_NONE)});
    tab.push_back(stim_row_t'{8'h33, 0, 0, 1, rec(KIND_ERROR, 8'h00, 0, 0, 1, ERR_TRAILING)});
    tab.push_back(stim_row_t'{8'h09, 0, 0, 0, nil});
    tab.push_back(stim_row_t'{8'h00, 1, 0, 0, nil});
    tab.push_back(stim_row_t'{8'hc0, 0, 0, 0, nil});
    tab.push_back(stim_row_t'{8'h04, 0, 0, 0, nil});
    tab.push_back(stim_row_t'{8'h80, 0, 1, 0, nil});
    tab.push_back(stim_row_t'{8'h01, 0, 0, 0, nil});
    tab.push_back(stim_row_t'{8'h00, 1, 0, 0, nil});
    tab.push_back(stim_row_t'{8'h40, 0, 0, 0, nil});
    tab.push_back(stim_row_t'{8'h02, 0, 0, 1, rec(KIND_RUN, 8'h00, 2, 0, 0, ERR_NONE)});
    tab.push_back(stim_row_t'{8'h00, 0, 0, 0, nil});
    tab.push_back(stim_row_t'{8'h00, 0, 0, 1, rec(KIND_ERROR, 8'h00, 0, 2, 0, ERR_LINE_LEN)});
    tab.push_back(stim_row_t'{8'h00, 1, 0, 0, nil});
    tab.push_back(stim_row_t'{8'h05, 0, 0, 1, rec(KIND_ERROR, 8'h00, 0, 0, 0, ERR_CROSSES)});
    tab.push_back(stim_row_t'{8'h00, 1, 1, 1, rec(KIND_ERROR, 8'h00, 0, 0, 0, ERR_TRUNCATED)});
    tab.push_back(stim_row_t'{8'h01, 1, 1, 0, nil});
    tab.push_back(stim_row_t'{8'h00, 1, 0, 0, nil});
    tab.push_back(stim_row_t'{8'h7f, 0, 0, 0, nil});
    tab.push_back(stim_row_t'{8'hff, 0, 0, 1, rec(KIND_ERROR, 8'h00, 0, 0, 0, ERR_CROSSES)});
    foreach (tab[k]) send_byte(tab[k].data, tab[k].first, tab[k].last, tab[k].typed,
                               tab[k].want, ign);
    drain_results();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_IMAGE_WIDTH, ph_w[p]);
      write_reg(REG_IMAGE_HEIGHT, ph_h[p]);
      send_idle_pct  = ph_idle[p];
      recv_stall_pct = ph_stall[p];
      counted = 0;
      while (counted < PER_PHASE) begin
        build_image();
        foreach (img_q[k]) begin
          send_byte(img_q[k].data, img_q[k].first, img_q[k].last, 1'b0, nil, ign);
          if (!ign) counted++;
        end
        if (p == 1 && !paused && counted >= PER_PHASE / 2) begin
          paused = 1'b1;
          drain_results();
        end
      end
      drain_results();
    end

    drain_results();
    if (errors == 0) begin
      $display("pgs_rle_run_decoder_tb: clean");
    end else begin
      $display("pgs_rle_run_decoder_tb: errors");
    end
    $finish;
  end

endmodule
